FILE: rtl/srmc_pkg.sv
// srmc_pkg: shared types and constants of the stepper ramp motion controller
// used by stepper_ramp_motion_controller_unit; depends on nothing
package srmc_pkg;

  // item operation codes
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_MOVE = 3'd1;
  localparam logic [2:0] OP_HOME = 3'd2;
  localparam logic [2:0] OP_STOP = 3'd3;
  localparam logic [2:0] OP_POLL = 3'd4;

  // motion outcome codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_STOPPED = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_X_START = 3'd0;
  localparam logic [2:0] REG_Y_START = 3'd1;
  localparam logic [2:0] REG_Z_START = 3'd2;
  localparam logic [2:0] REG_X_HOME  = 3'd3;
  localparam logic [2:0] REG_Y_HOME  = 3'd4;
  localparam logic [2:0] REG_Z_HOME  = 3'd5;
  localparam logic [2:0] REG_POL     = 3'd6;
  localparam logic [2:0] REG_MASK    = 3'd7;

  // field widths and limits
  localparam int RATE_W    = 15;
  localparam int STEPS_W   = 19;
  localparam int LEFT_W    = 18;
  localparam int PERIOD_W  = 20;
  localparam int DIV_W     = 24;
  localparam int MAX_STEPS = 200000;
  localparam int MAX_RATE  = 20000;
  localparam int US_PER_S  = 1000000;

  typedef enum logic [1:0] {
    MK_IDLE,
    MK_MOVE,
    MK_HOME
  } motion_kind_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_DIV1,
    SQ_ADJ,
    SQ_DIV2,
    SQ_WB,
    SQ_RESP
  } seq_state_t;

  // sequencer controls toward the datapath
  typedef struct packed {
    logic div_load_ramp;
    logic div_step;
    logic div_load_rate;
    logic period_wr;
    logic out_load;
  } seq_ctl_t;

endpackage

FILE: rtl/stepper_ramp_motion_controller_unit.sv
// stepper_ramp_motion_controller_unit: three-axis step/direction generator with ramps
// and homing, one shared iterative divider under a small sequencer; uses srmc_pkg
//
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+---------------------------
//  in      | in_valid/in_stall + item fields         | valid & !stall
//  out     | out_valid/out_stall + result fields     | valid & !stall
//  cfg     | psel penable pwrite paddr pwdata prdata | psel & penable & pwrite
//
// a request that needs a new step period runs the shared restoring divider twice
// (once for the ramp interpolation and once for 1e6/rate) before its result is loaded;
// any other request goes straight to the result. in_stall is high while a request is in work.
// synchronous active-low reset loads register defaults and clears motion state.
// a result waits in the output register until taken; the next result is not loaded before then.
module stepper_ramp_motion_controller_unit
  import srmc_pkg::*;
#(
  parameter int TICKS_PER_MS       = 1000,
  parameter int KEEPALIVE_LIMIT_MS = 5000,
  parameter int HOME_LIMIT_MS      = 120000,
  parameter int PULSE_TICKS        = 4,
  parameter int MAX_RAMP           = 100,
  parameter int NUM_AXES           = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_operation,
  input  logic [1:0]               in_axis,
  input  logic signed [STEPS_W-1:0] in_steps,
  input  logic [RATE_W-1:0]        in_rate,
  input  logic                     in_all_axes,
  input  logic [2:0]               in_endstop_levels,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_accepted,
  output logic                     out_step_level,
  output logic                     out_direction_level,
  output logic [1:0]               out_active_axis,
  output logic                     out_drivers_enabled,
  output logic [1:0]               out_run_state,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int PRE_W = $clog2(TICKS_PER_MS + 1);
  localparam int KA_W  = $clog2(KEEPALIVE_LIMIT_MS + 2);
  localparam int DL_W  = $clog2(HOME_LIMIT_MS + 1);
  localparam int RL_W  = $clog2(MAX_RAMP + 1);
  localparam int CNT_W = $clog2(DIV_W);

  // configuration registers
  logic [RATE_W-1:0] start_rate_r [3];
  logic [RATE_W-1:0] home_rate_r  [3];
  logic [5:0]        pol_r;
  logic [2:0]        mask_r;

  // motion state
  motion_kind_t      kind_r, kind_nxt;
  logic [1:0]        outcome_r, outcome_nxt;
  logic [1:0]        cur_r, cur_nxt;
  logic              hall_r, hall_nxt;
  logic              mpos_r, mpos_nxt;
  logic              pulse_r, pulse_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [RL_W-1:0]   done_r, done_nxt;
  logic [RATE_W-1:0] rstart_r, rstart_nxt;
  logic [RATE_W-1:0] rtgt_r, rtgt_nxt;
  logic [RL_W-1:0]   rlen_r, rlen_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] edge_r, edge_nxt;
  logic [PRE_W-1:0]  pre_r, pre_nxt;
  logic [KA_W-1:0]   ka_r, ka_nxt;
  logic [DL_W-1:0]   dl_r, dl_nxt;
  logic              acc_r, acc_nxt;
  logic              need_per_nxt;
  logic              need_edge_r, need_edge_nxt;

  // sequencer and shared divider
  seq_state_t        state_r, state_nxt;
  seq_ctl_t          ctl;
  logic [DIV_W-1:0]  dq_r;
  logic [RATE_W-1:0] drem_r;
  logic [RATE_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r;

  // result register
  logic              out_valid_r;
  logic              o_acc_r, o_step_r, o_dir_r, o_en_r;
  logic [1:0]        o_axis_r, o_stat_r;

  logic              in_take;
  logic              out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = (state_r != SQ_IDLE);
  assign pready   = 1'b1;

  function automatic logic hit(input logic [1:0] a, input logic [2:0] lv,
                               input logic [5:0] pol);
    logic r;
    begin
      r = 1'b1;
      case (a)
        2'd0:    r = (lv[0] == pol[3]);
        2'd1:    r = (lv[1] == pol[4]);
        2'd2:    r = (lv[2] == pol[5]);
        default: r = 1'b1;
      endcase
      return r;
    end
  endfunction

  // configuration write and read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_rate_r[0] <= RATE_W'(100);
      start_rate_r[1] <= RATE_W'(20);
      start_rate_r[2] <= RATE_W'(100);
      home_rate_r[0]  <= RATE_W'(400);
      home_rate_r[1]  <= RATE_W'(100);
      home_rate_r[2]  <= RATE_W'(400);
      pol_r           <= 6'd62;
      mask_r          <= 3'd5;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_X_START: start_rate_r[0] <= pwdata[RATE_W-1:0];
        REG_Y_START: start_rate_r[1] <= pwdata[RATE_W-1:0];
        REG_Z_START: start_rate_r[2] <= pwdata[RATE_W-1:0];
        REG_X_HOME:  home_rate_r[0]  <= pwdata[RATE_W-1:0];
        REG_Y_HOME:  home_rate_r[1]  <= pwdata[RATE_W-1:0];
        REG_Z_HOME:  home_rate_r[2]  <= pwdata[RATE_W-1:0];
        REG_POL:     pol_r           <= pwdata[5:0];
        REG_MASK:    mask_r          <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_X_START: prdata = 32'(start_rate_r[0]);
      REG_Y_START: prdata = 32'(start_rate_r[1]);
      REG_Z_START: prdata = 32'(start_rate_r[2]);
      REG_X_HOME:  prdata = 32'(home_rate_r[0]);
      REG_Y_HOME:  prdata = 32'(home_rate_r[1]);
      REG_Z_HOME:  prdata = 32'(home_rate_r[2]);
      REG_POL:     prdata = 32'(pol_r);
      REG_MASK:    prdata = 32'(mask_r);
      default:     prdata = '0;
    endcase
  end

  // request decode: every state update except the step period and its edge reload
  always_comb begin
    logic [LEFT_W-1:0]   mag;
    logic [LEFT_W-2:0]   half;
    logic [PRE_W-1:0]    pre_inc;
    logic [PERIOD_W-1:0] ew;
    logic                go;
    logic                do_home;
    logic [1:0]          hax;
    logic                stop;
    logic                fin;
    logic [RATE_W-1:0]   cstart;

    kind_nxt      = kind_r;
    outcome_nxt   = outcome_r;
    cur_nxt       = cur_r;
    hall_nxt      = hall_r;
    mpos_nxt      = mpos_r;
    pulse_nxt     = pulse_r;
    left_nxt      = left_r;
    done_nxt      = done_r;
    rstart_nxt    = rstart_r;
    rtgt_nxt      = rtgt_r;
    rlen_nxt      = rlen_r;
    edge_nxt      = edge_r;
    pre_nxt       = pre_r;
    ka_nxt        = ka_r;
    dl_nxt        = dl_r;
    acc_nxt       = 1'b0;
    need_per_nxt  = 1'b0;
    need_edge_nxt = 1'b0;
    do_home       = 1'b0;
    hax           = in_axis;
    mag           = in_steps[STEPS_W-1] ? LEFT_W'(-in_steps) : LEFT_W'(in_steps);
    half          = mag[LEFT_W-1:1];
    pre_inc       = pre_r + 1'b1;
    ew            = '0;
    go            = 1'b0;
    stop          = 1'b0;
    fin           = 1'b0;
    cstart        = start_rate_r[2];

    case (in_operation)
      OP_TICK: begin
        // millisecond clock and its counters
        if (pre_inc >= PRE_W'(TICKS_PER_MS)) begin
          pre_nxt = '0;
          if (ka_r <= KA_W'(KEEPALIVE_LIMIT_MS)) ka_nxt = ka_r + 1'b1;
          if (dl_r < DL_W'(HOME_LIMIT_MS)) dl_nxt = dl_r + 1'b1;
        end else begin
          pre_nxt = pre_inc;
        end
        // keepalive watchdog
        if (kind_r != MK_IDLE && ka_nxt > KA_W'(KEEPALIVE_LIMIT_MS)) begin
          kind_nxt    = MK_IDLE;
          outcome_nxt = ST_ERROR;
          pulse_nxt   = 1'b0;
        end
        go = (kind_nxt != MK_IDLE);
        // endstop and deadline checks
        if (go && kind_r == MK_HOME) begin
          if (hit(cur_r, in_endstop_levels, pol_r)) begin
            pulse_nxt = 1'b0;
            go        = 1'b0;
            if (hall_r && ({1'b0, cur_r} + 3'd1 < 3'(NUM_AXES))) begin
              do_home = 1'b1;
              hax     = cur_r + 2'd1;
            end else begin
              kind_nxt    = MK_IDLE;
              outcome_nxt = ST_DONE;
            end
          end else if (dl_nxt >= DL_W'(HOME_LIMIT_MS)) begin
            go          = 1'b0;
            kind_nxt    = MK_IDLE;
            outcome_nxt = ST_ERROR;
            pulse_nxt   = 1'b0;
          end
        end else if (go && mask_r[cur_r] && !mpos_r &&
                     hit(cur_r, in_endstop_levels, pol_r)) begin
          go          = 1'b0;
          kind_nxt    = MK_IDLE;
          outcome_nxt = ST_DONE;
          pulse_nxt   = 1'b0;
        end
        // step edge timing
        if (go) begin
          ew       = (edge_r == '0) ? '0 : edge_r - 1'b1;
          edge_nxt = ew;
          if (ew == '0) begin
            if (!pulse_r) begin
              if (kind_r == MK_MOVE && left_r == '0) begin
                kind_nxt    = MK_IDLE;
                outcome_nxt = ST_DONE;
                pulse_nxt   = 1'b0;
              end else begin
                pulse_nxt = 1'b1;
                edge_nxt  = PERIOD_W'(PULSE_TICKS);
              end
            end else begin
              pulse_nxt = 1'b0;
              if (kind_r == MK_MOVE && left_r != '0) left_nxt = left_r - 1'b1;
              if (done_r != '1) done_nxt = done_r + 1'b1;
              need_per_nxt  = 1'b1;
              need_edge_nxt = 1'b1;
            end
          end
        end
      end
      OP_MOVE: begin
        if (({1'b0, in_axis} < 3'(NUM_AXES)) && in_steps >= -MAX_STEPS &&
            in_steps <= MAX_STEPS && in_rate >= RATE_W'(1) &&
            in_rate <= RATE_W'(MAX_RATE)) begin
          if (in_steps == '0) begin
            acc_nxt = 1'b1;
          end else if (kind_r == MK_IDLE) begin
            acc_nxt = 1'b1;
            case (in_axis)
              2'd0:    cstart = start_rate_r[0];
              2'd1:    cstart = start_rate_r[1];
              default: cstart = start_rate_r[2];
            endcase
            cur_nxt    = in_axis;
            mpos_nxt   = !in_steps[STEPS_W-1];
            left_nxt   = mag;
            done_nxt   = '0;
            rstart_nxt = (cstart < in_rate) ? cstart : in_rate;
            rtgt_nxt   = in_rate;
            if (half == '0) rlen_nxt = RL_W'(1);
            else if (half > (LEFT_W-1)'(MAX_RAMP)) rlen_nxt = RL_W'(MAX_RAMP);
            else rlen_nxt = RL_W'(half);
            kind_nxt     = MK_MOVE;
            need_per_nxt = 1'b1;
            edge_nxt     = '0;
            outcome_nxt  = ST_RUNNING;
            ka_nxt       = '0;
            pulse_nxt    = 1'b0;
          end
        end
      end
      OP_HOME: begin
        if ((in_all_axes || ({1'b0, in_axis} < 3'(NUM_AXES))) && kind_r == MK_IDLE) begin
          acc_nxt  = 1'b1;
          ka_nxt   = '0;
          hall_nxt = in_all_axes;
          do_home  = 1'b1;
          hax      = in_all_axes ? 2'd0 : in_axis;
        end
      end
      OP_STOP: begin
        acc_nxt     = 1'b1;
        kind_nxt    = MK_IDLE;
        outcome_nxt = ST_STOPPED;
        pulse_nxt   = 1'b0;
      end
      OP_POLL: begin
        acc_nxt = 1'b1;
        if (outcome_r == ST_RUNNING) ka_nxt = '0;
      end
      default: ;
    endcase

    // homing start: skip axes already on their endstop when homing all
    if (do_home) begin
      for (int i = 0; i < 3; i++) begin
        if (!stop) begin
          cur_nxt = hax;
          if (!hit(hax, in_endstop_levels, pol_r)) begin
            stop = 1'b1;
          end else if (hall_nxt && ({1'b0, hax} + 3'd1 < 3'(NUM_AXES))) begin
            hax = hax + 2'd1;
          end else begin
            stop = 1'b1;
            fin  = 1'b1;
          end
        end
      end
      if (fin || !stop) begin
        kind_nxt    = MK_IDLE;
        outcome_nxt = ST_DONE;
        pulse_nxt   = 1'b0;
      end else begin
        mpos_nxt = 1'b0;
        done_nxt = '0;
        case (hax)
          2'd0: begin
            rstart_nxt = start_rate_r[0];
            rtgt_nxt   = home_rate_r[0];
          end
          2'd1: begin
            rstart_nxt = start_rate_r[1];
            rtgt_nxt   = home_rate_r[1];
          end
          default: begin
            rstart_nxt = start_rate_r[2];
            rtgt_nxt   = home_rate_r[2];
          end
        endcase
        rlen_nxt      = RL_W'(MAX_RAMP);
        kind_nxt      = MK_HOME;
        need_per_nxt  = 1'b1;
        need_edge_nxt = 1'b0;
        edge_nxt      = '0;
        dl_nxt        = '0;
        outcome_nxt   = ST_RUNNING;
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: if (in_take) state_nxt = need_per_nxt ? SQ_MUL : SQ_RESP;
      SQ_MUL:  state_nxt = SQ_DIV1;
      SQ_DIV1: if (cnt_r == CNT_W'(DIV_W - 1)) state_nxt = SQ_ADJ;
      SQ_ADJ:  state_nxt = SQ_DIV2;
      SQ_DIV2: if (cnt_r == CNT_W'(DIV_W - 1)) state_nxt = SQ_WB;
      SQ_WB:   state_nxt = SQ_RESP;
      SQ_RESP: if (!out_valid_r || !out_stall) state_nxt = SQ_IDLE;
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      SQ_MUL:  ctl.div_load_ramp = 1'b1;
      SQ_DIV1: ctl.div_step      = 1'b1;
      SQ_ADJ:  ctl.div_load_rate = 1'b1;
      SQ_DIV2: ctl.div_step      = 1'b1;
      SQ_WB:   ctl.period_wr     = 1'b1;
      SQ_RESP: ctl.out_load      = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // ramp position, interpolation product and rate correction
  logic [RL_W-1:0]            pos;
  logic signed [RATE_W:0]     delta;
  logic signed [RATE_W+RL_W+1:0] prod;
  logic [RATE_W:0]            rem_sh;
  logic                       ge;
  logic signed [RATE_W+1:0]   qs;
  logic signed [RATE_W+1:0]   rs;
  logic [RATE_W-1:0]          rnew;
  logic [PERIOD_W-1:0]        per;

  always_comb begin
    pos = (done_r < rlen_r) ? done_r + 1'b1 : rlen_r;
    if (kind_r == MK_MOVE && ((LEFT_W+1)'(pos) > (LEFT_W+1)'(left_r) + 1'b1))
      pos = RL_W'(left_r + 1'b1);
    delta  = $signed({1'b0, rtgt_r}) - $signed({1'b0, rstart_r});
    prod   = delta * $signed({1'b0, pos});
    rem_sh = {drem_r, dq_r[DIV_W-1]};
    ge     = (rem_sh >= {1'b0, dvs_r});
    qs     = $signed({2'b00, dq_r[RATE_W-1:0]});
    rs     = $signed({2'b00, rstart_r}) + (neg_r ? -qs : qs);
    rnew   = (rs <= 0) ? RATE_W'(1) : rs[RATE_W-1:0];
    per    = dq_r[PERIOD_W-1:0];
  end

  // shared divider
  always_ff @(posedge clk) begin
    if (ctl.div_load_ramp) begin
      dq_r   <= prod[RATE_W+RL_W+1] ? DIV_W'(-prod) : DIV_W'(prod);
      neg_r  <= prod[RATE_W+RL_W+1];
      drem_r <= '0;
      dvs_r  <= RATE_W'(rlen_r);
      cnt_r  <= '0;
    end else if (ctl.div_load_rate) begin
      dq_r   <= DIV_W'(US_PER_S);
      drem_r <= '0;
      dvs_r  <= rnew;
      cnt_r  <= '0;
    end else if (ctl.div_step) begin
      dq_r   <= {dq_r[DIV_W-2:0], ge};
      drem_r <= ge ? RATE_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[RATE_W-1:0];
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // motion state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      kind_r      <= MK_IDLE;
      outcome_r   <= ST_DONE;
      cur_r       <= '0;
      hall_r      <= 1'b0;
      mpos_r      <= 1'b0;
      pulse_r     <= 1'b0;
      left_r      <= '0;
      done_r      <= '0;
      rstart_r    <= '0;
      rtgt_r      <= '0;
      rlen_r      <= RL_W'(1);
      period_r    <= '0;
      edge_r      <= '0;
      pre_r       <= '0;
      ka_r        <= '0;
      dl_r        <= '0;
      acc_r       <= 1'b0;
      need_edge_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_take) begin
        kind_r      <= kind_nxt;
        outcome_r   <= outcome_nxt;
        cur_r       <= cur_nxt;
        hall_r      <= hall_nxt;
        mpos_r      <= mpos_nxt;
        pulse_r     <= pulse_nxt;
        left_r      <= left_nxt;
        done_r      <= done_nxt;
        rstart_r    <= rstart_nxt;
        rtgt_r      <= rtgt_nxt;
        rlen_r      <= rlen_nxt;
        edge_r      <= edge_nxt;
        pre_r       <= pre_nxt;
        ka_r        <= ka_nxt;
        dl_r        <= dl_nxt;
        acc_r       <= acc_nxt;
        need_edge_r <= need_edge_nxt;
      end else if (ctl.period_wr) begin
        period_r <= per;
        if (need_edge_r)
          edge_r <= (per > PERIOD_W'(PULSE_TICKS)) ? per - PERIOD_W'(PULSE_TICKS)
                                                   : PERIOD_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      o_acc_r  <= acc_r;
      o_step_r <= pulse_r;
      o_dir_r  <= mpos_r ^ pol_r[cur_r];
      o_axis_r <= cur_r;
      o_en_r   <= (kind_r != MK_IDLE);
      o_stat_r <= outcome_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = o_acc_r;
  assign out_step_level      = o_step_r;
  assign out_direction_level = o_dir_r;
  assign out_active_axis     = o_axis_r;
  assign out_drivers_enabled = o_en_r;
  assign out_run_state       = o_stat_r;

  // motion running always reports a running outcome
  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r != MK_IDLE) |-> (outcome_r == ST_RUNNING))
    else $error("motion active without running outcome");

  // a step pulse only exists during motion
  a_pulse_motion: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r |-> (kind_r != MK_IDLE))
    else $error("step pulse high while idle");

  // an accepted request leaves the sequencer busy
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != SQ_IDLE))
    else $error("sequencer idle after request");

  // active axis stays in range
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_r} < 3'(NUM_AXES)))
    else $error("active axis out of range");

endmodule

FILE: tb/stepper_ramp_motion_controller_unit_tb.sv
// stepper_ramp_motion_controller_unit_tb: self-checking bench for the stepper ramp controller
// drives requests, register writes and output stalls; predicts every result; uses srmc_pkg
module stepper_ramp_motion_controller_unit_tb;
  import srmc_pkg::*;

  localparam int PULSE_T   = 4;
  localparam int MS_TICKS  = 1000;
  localparam int KEEP_MS   = 5000;
  localparam int HOME_MS   = 120000;
  localparam int RAMP_MAX  = 100;
  localparam int AXES      = 3;
  localparam int BUSY_WAIT = 60;
  localparam int WD_LIMIT  = 3000;

  typedef struct {
    logic [2:0]         op;
    logic [1:0]         axis;
    logic signed [18:0] steps;
    logic [14:0]        rate;
    logic               all_axes;
    logic [2:0]         levels;
  } motion_req_t;

  typedef struct {
    logic       acc;
    logic       step;
    logic       dir;
    logic [1:0] axis;
    logic       drv;
    logic [1:0] status;
  } motion_res_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_operation;
  logic [1:0] in_axis;
  logic signed [STEPS_W-1:0] in_steps;
  logic [RATE_W-1:0] in_rate;
  logic in_all_axes;
  logic [2:0] in_endstop_levels;
  logic out_valid, out_stall;
  logic out_accepted, out_step_level, out_direction_level, out_drivers_enabled;
  logic [1:0] out_active_axis, out_run_state;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  stepper_ramp_motion_controller_unit i_dut (.*);

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // shadow registers and motion state of the predictor
  longint cfg_shadow[8];
  motion_kind_t m_kind;
  logic [1:0] m_outcome;
  int m_axis;
  bit m_all, m_pos, m_pulse;
  longint m_left, m_done, m_rstart, m_rtgt, m_rlen, m_period, m_wait;
  longint m_prescale, m_keep, m_deadline;

  motion_res_t expected_results[$];
  int  fail_cnt;
  int  idle_cycles;
  bit  gaps_on;

  function automatic bit endstop_active(int ax, logic [2:0] lv);
    return lv[ax] == cfg_shadow[REG_POL][3 + ax];
  endfunction

  function automatic void motion_end(logic [1:0] o);
    m_kind = MK_IDLE;
    m_outcome = o;
    m_pulse = 0;
  endfunction

  // linear ramp interpolation, then 1e6 / rate
  function automatic void refresh_period();
    longint len, pos, r;
    len = m_rlen != 0 ? m_rlen : 1;
    pos = m_done < len ? m_done + 1 : len;
    if (m_kind == MK_MOVE && pos > m_left + 1) pos = m_left + 1;
    r = m_rstart + ((m_rtgt - m_rstart) * pos) / len;
    if (r <= 0) r = 1;
    m_period = 1000000 / r;
  endfunction

  function automatic void start_homing(int ax, logic [2:0] lv);
    forever begin
      m_axis = ax;
      if (!endstop_active(ax, lv)) break;
      if (m_all && ax + 1 < AXES) begin
        ax++;
      end else begin
        motion_end(ST_DONE);
        return;
      end
    end
    m_pos = 0;
    m_done = 0;
    m_rstart = cfg_shadow[ax];
    m_rtgt = cfg_shadow[3 + ax];
    m_rlen = RAMP_MAX;
    m_kind = MK_HOME;
    refresh_period();
    m_wait = 0;
    m_deadline = 0;
    m_outcome = ST_RUNNING;
  endfunction

  // per-tick motion service
  function automatic void serve_tick(logic [2:0] lv);
    int ax;
    ax = m_axis;
    if (m_kind == MK_IDLE) return;
    if (m_kind == MK_HOME) begin
      if (endstop_active(ax, lv)) begin
        m_pulse = 0;
        if (m_all && ax + 1 < AXES) start_homing(ax + 1, lv);
        else motion_end(ST_DONE);
        return;
      end
      if (m_deadline >= HOME_MS) begin
        motion_end(ST_ERROR);
        return;
      end
    end else if (cfg_shadow[REG_MASK][ax] && !m_pos && endstop_active(ax, lv)) begin
      motion_end(ST_DONE);
      return;
    end
    if (m_wait > 0) m_wait--;
    if (m_wait > 0) return;
    if (!m_pulse) begin
      if (m_kind == MK_MOVE && m_left == 0) begin
        motion_end(ST_DONE);
        return;
      end
      m_pulse = 1;
      m_wait = PULSE_T;
    end else begin
      m_pulse = 0;
      if (m_kind == MK_MOVE && m_left > 0) m_left--;
      if (m_done != 64'hFFFF_FFFF) m_done++;
      refresh_period();
      m_wait = m_period > PULSE_T ? m_period - PULSE_T : 1;
    end
  endfunction

  function automatic motion_res_t motion_predict(motion_req_t r);
    motion_res_t res;
    bit acc;
    longint s;
    acc = 0;
    s = r.steps;
    case (r.op)
      OP_TICK: begin
        m_prescale++;
        if (m_prescale >= MS_TICKS) begin
          m_prescale = 0;
          if (m_keep <= KEEP_MS) m_keep++;
          if (m_deadline < HOME_MS) m_deadline++;
        end
        if (m_kind != MK_IDLE && m_keep > KEEP_MS) motion_end(ST_ERROR);
        serve_tick(r.levels);
      end
      OP_MOVE: begin
        if (r.axis < AXES && s >= -MAX_STEPS && s <= MAX_STEPS &&
            r.rate >= 1 && r.rate <= MAX_RATE) begin
          if (s == 0) begin
            acc = 1;
          end else if (m_kind == MK_IDLE) begin
            acc = 1;
            m_axis = r.axis;
            m_pos = s > 0;
            m_left = s > 0 ? s : -s;
            m_done = 0;
            m_rstart = cfg_shadow[r.axis] < r.rate ? cfg_shadow[r.axis] : r.rate;
            m_rtgt = r.rate;
            m_rlen = m_left / 2;
            if (m_rlen == 0) m_rlen = 1;
            if (m_rlen > RAMP_MAX) m_rlen = RAMP_MAX;
            m_kind = MK_MOVE;
            refresh_period();
            m_wait = 0;
            m_outcome = ST_RUNNING;
            m_keep = 0;
            m_pulse = 0;
          end
        end
      end
      OP_HOME: begin
        if ((r.all_axes || r.axis < AXES) && m_kind == MK_IDLE) begin
          acc = 1;
          m_keep = 0;
          m_all = r.all_axes;
          start_homing(r.all_axes ? 0 : int'(r.axis), r.levels);
        end
      end
      OP_STOP: begin
        acc = 1;
        motion_end(ST_STOPPED);
      end
      OP_POLL: begin
        acc = 1;
        if (m_outcome == ST_RUNNING) m_keep = 0;
      end
      default: ;
    endcase
    res.acc = acc;
    res.step = m_pulse;
    res.dir = m_pos ^ cfg_shadow[REG_POL][m_axis];
    res.axis = m_axis[1:0];
    res.drv = m_kind != MK_IDLE;
    res.status = m_outcome;
    return res;
  endfunction

  // send one request, predict its result at acceptance
  task automatic send_req(motion_req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= r.op;
    in_axis <= r.axis;
    in_steps <= r.steps;
    in_rate <= r.rate;
    in_all_axes <= r.all_axes;
    in_endstop_levels <= r.levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(motion_predict(r));
  endtask

  // register write, only while idle
  task automatic reg_write(logic [2:0] idx, longint val);
    in_valid <= 0;
    wait (expected_results.size() == 0);
    repeat (BUSY_WAIT) @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val[31:0];
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    cfg_shadow[idx] = idx == REG_POL ? val % 64 : idx == REG_MASK ? val % 8 : val % 32768;
  endtask

  function automatic motion_req_t mk_req(logic [2:0] op, logic [1:0] ax, int st, int rt,
                                        bit all, logic [2:0] lv);
    motion_req_t r;
    r.op = op;
    r.axis = ax;
    r.steps = 19'(st);
    r.rate = 15'(rt);
    r.all_axes = all;
    r.levels = lv;
    return r;
  endfunction

  function automatic motion_req_t rand_req();
    motion_req_t r;
    int p;
    r.op = OP_TICK;
    r.axis = 2'($urandom_range(0, 3));
    r.steps = 19'($urandom);
    r.rate = 15'($urandom);
    r.all_axes = 1'($urandom_range(0, 1));
    r.levels = 3'($urandom);
    p = $urandom_range(0, 99);
    if (p < 55) r.op = OP_TICK;
    else if (p < 72) r.op = OP_MOVE;
    else if (p < 80) r.op = OP_HOME;
    else if (p < 84) r.op = OP_STOP;
    else if (p < 96) r.op = OP_POLL;
    else r.op = 3'($urandom_range(5, 7));
    if (r.op == OP_MOVE) begin
      if ($urandom_range(0, 3) != 0) r.axis = 2'($urandom_range(0, 2));
      p = $urandom_range(0, 9);
      if (p < 7) r.steps = $urandom_range(0, 1) ? 19'($urandom_range(1, 6))
                                                : 19'(-int'($urandom_range(1, 6)));
      else if (p == 7) r.steps = 19'(0);
      else if (p == 8) r.steps = $urandom_range(0, 1) ? 19'(200001) : 19'(-200001);
      p = $urandom_range(0, 19);
      if (p < 15) r.rate = 15'($urandom_range(5000, 20000));
      else if (p < 18) r.rate = 15'($urandom_range(1, 20000));
    end
    return r;
  endfunction

  // result check against the oldest prediction, plus output stall pattern
  int stall_cnt;
  always @(posedge clk) begin
    motion_res_t e;
    if (!rst_n) begin
      out_stall <= 0;
      stall_cnt = 0;
    end else if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending");
        fail_cnt++;
      end else begin
        e = expected_results.pop_front();
        if (out_accepted !== e.acc) begin
          $error("accepted exp %0d got %0d", e.acc, out_accepted); fail_cnt++;
        end
        if (out_step_level !== e.step) begin
          $error("step_level exp %0d got %0d", e.step, out_step_level); fail_cnt++;
        end
        if (out_direction_level !== e.dir) begin
          $error("direction_level exp %0d got %0d", e.dir, out_direction_level); fail_cnt++;
        end
        if (out_active_axis !== e.axis) begin
          $error("active_axis exp %0d got %0d", e.axis, out_active_axis); fail_cnt++;
        end
        if (out_drivers_enabled !== e.drv) begin
          $error("drivers_enabled exp %0d got %0d", e.drv, out_drivers_enabled); fail_cnt++;
        end
        if (out_run_state !== e.status) begin
          $error("run_state exp %0d got %0d", e.status, out_run_state); fail_cnt++;
        end
      end
      stall_cnt = gaps_on ? $urandom_range(0, 14) : 0;
      out_stall <= stall_cnt != 0;
    end else if (stall_cnt > 1) begin
      stall_cnt--;
      out_stall <= 1;
    end else begin
      stall_cnt = 0;
      out_stall <= 0;
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("[stepper_ramp_motion_controller_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // operations, extremes and special cases
  task automatic test_directed();
    send_req(mk_req(OP_TICK, 0, 0, 1, 0, 3'b000));
    send_req(mk_req(OP_STOP, 0, 0, 1, 0, 3'b000));
    send_req(mk_req(OP_POLL, 0, 0, 1, 0, 3'b000));
    send_req(mk_req(3'd5, 3, -1, 32767, 1, 3'b111));
    send_req(mk_req(3'd7, 0, 0, 0, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 3, 5, 100, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 0, 200001, 100, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 0, -200001, 100, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 0, 5, 0, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 0, 5, 20001, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 1, 0, 20000, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 2, 200000, 20000, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 1, -3, 20000, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 1, 0, 1, 0, 3'b000));
    send_req(mk_req(OP_HOME, 0, 0, 1, 1, 3'b000));
    repeat (3) send_req(mk_req(OP_TICK, 0, 0, 1, 0, 3'b010));
    send_req(mk_req(OP_STOP, 0, 0, 1, 0, 3'b000));
    send_req(mk_req(OP_MOVE, 0, -200000, 1, 0, 3'b000));
    send_req(mk_req(OP_STOP, 0, 0, 1, 0, 3'b000));
    send_req(mk_req(OP_HOME, 3, 0, 1, 0, 3'b000));
    send_req(mk_req(OP_HOME, 0, 0, 1, 1, 3'b111));
    send_req(mk_req(OP_HOME, 1, 0, 1, 0, 3'b101));
    send_req(mk_req(OP_TICK, 0, 0, 1, 0, 3'b111));
  endtask

  // register sweep with random traffic in each setting
  task automatic test_settings();
    reg_write(REG_X_START, 20000);
    reg_write(REG_Y_START, 0);
    reg_write(REG_Z_START, 1);
    reg_write(REG_X_HOME, 20000);
    reg_write(REG_Y_HOME, 20000);
    reg_write(REG_Z_HOME, 1);
    reg_write(REG_POL, 0);
    reg_write(REG_MASK, 7);
    repeat (100) send_req(rand_req());
    reg_write(REG_Y_START, 20000);
    reg_write(REG_Z_START, 15000);
    reg_write(REG_Z_HOME, 20000);
    reg_write(REG_POL, 63);
    reg_write(REG_MASK, 0);
    repeat (100) send_req(rand_req());
  endtask

  // random traffic, one stretch without gaps
  task automatic test_random_mix();
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_POL, $urandom_range(0, 63));
      reg_write(REG_MASK, $urandom_range(0, 7));
      reg_write(REG_X_START, $urandom_range(1000, 20000));
      gaps_on = ph != 2;
      repeat (50) send_req(rand_req());
    end
    gaps_on = 1;
  endtask

  // sender holds off until every result is back
  task automatic test_drain_pause();
    repeat (10) send_req(rand_req());
    in_valid <= 0;
    wait (expected_results.size() == 0);
    @(posedge clk);
    repeat (20) send_req(rand_req());
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_operation = OP_TICK;
    in_axis = 0;
    in_steps = 0;
    in_rate = 1;
    in_all_axes = 0;
    in_endstop_levels = 0;
    out_stall = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    fail_cnt = 0;
    gaps_on = 1;
    cfg_shadow = '{100, 20, 100, 400, 100, 400, 62, 5};
    m_kind = MK_IDLE;
    m_outcome = ST_DONE;
    m_axis = 0;
    m_all = 0; m_pos = 0; m_pulse = 0;
    m_left = 0; m_done = 0; m_rstart = 0; m_rtgt = 0; m_rlen = 1;
    m_period = 0; m_wait = 0; m_prescale = 0; m_keep = 0; m_deadline = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_directed();
    test_settings();
    test_random_mix();
    test_drain_pause();

    // drain
    in_valid <= 0;
    wait (expected_results.size() == 0);
    repeat (BUSY_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[stepper_ramp_motion_controller_unit] OK");
    end else begin
      $display("[stepper_ramp_motion_controller_unit] ERROR");
    end
    $finish;
  end

endmodule
